// File: src/kfe_pkg.sv
`default_nettype none

package kfe_pkg;

    localparam int CAT_W   = 2;
    localparam int UNIT_W  = 17;
    localparam int VAL_W   = 24;
    localparam int TS_W    = 63;
    localparam int NOISE_W = 17;

    typedef enum logic [CAT_W-1:0] {
        CAT_NONE = 2'd0,
        CAT_NAV  = 2'd1,
        CAT_RISK = 2'd2,
        CAT_VOL  = 2'd3
    } t_category;

    // 3 * log2(e) in Q30
    localparam int                     EXP_SCALE_W = 33;
    localparam int                     EXP_Q       = 30;
    localparam logic [EXP_SCALE_W-1:0] EXP_SCALE   = 33'd4647246015;

    // 2^(k/16) in Q16, k = 0..16
    localparam int TBL_W      = 18;
    localparam int TBL_Q      = 16;
    localparam int TBL_IDX_W  = 4;
    localparam int TBL_STEP_W = 13;
    localparam logic [TBL_W-1:0] POW2_FRAC [0:16] = '{
        18'd65536,  18'd68438,  18'd71468,  18'd74632,
        18'd77936,  18'd81386,  18'd84990,  18'd88752,
        18'd92682,  18'd96785,  18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120193, 18'd125514,
        18'd131072
    };

    function automatic logic [VAL_W-1:0] sat_val(input logic [VAL_W:0] v);
        return v[VAL_W] ? {VAL_W{1'b1}} : v[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/kfe_if.sv
`default_nettype none

interface kfe_obs_if;
    logic                         valid;
    logic                         ready;
    logic [kfe_pkg::CAT_W-1:0]    category;
    logic [kfe_pkg::UNIT_W-1:0]   reliability;
    logic [kfe_pkg::UNIT_W-1:0]   severity;
    logic                         has_volume_value;
    logic [kfe_pkg::VAL_W-1:0]    volume_value;
    logic [kfe_pkg::TS_W-1:0]     timestamp;

    modport source (
        output valid, category, reliability, severity, has_volume_value,
               volume_value, timestamp,
        input  ready
    );
    modport sink (
        input  valid, category, reliability, severity, has_volume_value,
               volume_value, timestamp,
        output ready
    );
endinterface

interface kfe_est_if;
    logic                         valid;
    logic                         ready;
    logic [kfe_pkg::VAL_W-1:0]    navigability_out;
    logic [kfe_pkg::VAL_W-1:0]    volume_out;
    logic [kfe_pkg::VAL_W-1:0]    risk_out;
    logic [kfe_pkg::VAL_W-1:0]    penalty_out;
    logic [kfe_pkg::TS_W-1:0]     stamp_out;

    modport source (
        output valid, navigability_out, volume_out, risk_out, penalty_out,
               stamp_out,
        input  ready
    );
    modport sink (
        input  valid, navigability_out, volume_out, risk_out, penalty_out,
               stamp_out,
        output ready
    );
endinterface

`default_nettype wire

// File: src/three_channel_scalar_kalman_estimator_unit.sv
// Channel   Dir   Handshake        Payload
// i_obs     in    valid/ready      category, reliability, severity, volume, timestamp
// o_est     out   valid/ready      navigability, volume, risk, penalty, stamp
// apb       in    psel/penable     noise variance at byte address 0
//
// One observation at a time; i_obs.ready is high only while idle.
// A channel update runs the divider, then both multipliers side by side, FRACTION_BITS
// steps each, before o_est loads; an observation with no update skips all three.
// A positive overflow adds the 24-step exponential multiply.
// i_obs.ready is high again once the result loads; a stalled o_est holds the next
// result in the last step. Synchronous active-low reset, no clearing pass.
`default_nettype none

module three_channel_scalar_kalman_estimator_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kfe_obs_if.sink     i_obs,
    kfe_est_if.source   o_est,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW  = kfe_pkg::VAL_W;
    localparam int R_W = FRACTION_BITS + 2;

    localparam logic [VW-1:0] ONE        = VW'(2 ** FRACTION_BITS);
    localparam logic [VW-1:0] HALF       = VW'(2 ** (FRACTION_BITS - 1));
    localparam logic [VW-1:0] EPS        = VW'((2 ** FRACTION_BITS + 50) / 100);
    localparam logic [VW-1:0] RISK_LIMIT = VW'((2 ** FRACTION_BITS * 6 + 5) / 10);
    localparam logic          REG_NOISE  = 1'b0;
    localparam logic [kfe_pkg::NOISE_W-1:0] NOISE_RESET = 17'd655;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NOISE,
        S_SEL,
        S_DIV,
        S_MUL,
        S_UPD,
        S_CAP,
        S_PEN,
        S_EXP,
        S_DONE
    } t_state;

    t_state r_state;

    logic [kfe_pkg::NOISE_W-1:0] r_noise;

    logic [VW-1:0] r_est_nav, r_est_vol, r_est_risk, r_pen;
    logic [VW-1:0] r_var_nav, r_var_vol, r_var_risk;

    logic          r_out_valid;
    logic [VW-1:0] r_out_nav, r_out_vol, r_out_risk, r_out_pen;
    logic [kfe_pkg::TS_W-1:0] r_out_ts;

    kfe_pkg::t_category          r_cat;
    logic [kfe_pkg::UNIT_W-1:0]  r_rel, r_sev;
    logic                        r_has_vol;
    logic [VW-1:0]               r_vol;
    logic [kfe_pkg::TS_W-1:0]    r_ts;
    logic [R_W-1:0]              r_r;
    logic [VW-1:0]               r_p, r_x, r_diff;
    logic                        r_up;

    logic [VW-1:0] n_var_nav, n_var_vol, n_var_risk;
    logic [VW-1:0] w_rel_c, w_sev_c;
    logic [VW-1:0] w_p, w_x, w_z;
    logic [VW:0]   w_den;
    logic          w_active;
    logic [VW-1:0] w_x_new, w_p_new, w_cap;

    logic                     w_div_done;
    logic [FRACTION_BITS-1:0] w_gain;
    logic                     w_mul_done;
    logic [VW-1:0]            w_var_hi, w_step_hi;
    logic                     w_var_sticky;
    logic                     w_exp_done;
    logic [VW-1:0]            w_exp;
    logic                     w_cfg_wr;

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NOISE);
    assign prdata   = (paddr[2] == REG_NOISE) ? 32'(r_noise) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= NOISE_RESET;
        end else if (w_cfg_wr) begin
            r_noise <= pwdata[kfe_pkg::NOISE_W-1:0];
        end
    end

    assign n_var_nav  = kfe_pkg::sat_val({1'b0, r_var_nav} + (VW+1)'(r_noise));
    assign n_var_vol  = kfe_pkg::sat_val({1'b0, r_var_vol} + (VW+1)'(r_noise));
    assign n_var_risk = kfe_pkg::sat_val({1'b0, r_var_risk} + (VW+1)'(r_noise));

    assign w_rel_c  = (VW'(r_rel) > ONE) ? ONE : VW'(r_rel);
    assign w_sev_c  = (VW'(r_sev) > ONE) ? ONE : VW'(r_sev);
    assign w_active = (r_cat == kfe_pkg::CAT_NAV) || (r_cat == kfe_pkg::CAT_RISK)
                   || ((r_cat == kfe_pkg::CAT_VOL) && r_has_vol);

    always_comb begin
        unique case (r_cat)
            kfe_pkg::CAT_NAV: begin
                w_p = r_var_nav;
                w_x = r_est_nav;
                w_z = ONE - w_sev_c;
            end
            kfe_pkg::CAT_RISK: begin
                w_p = r_var_risk;
                w_x = r_est_risk;
                w_z = w_sev_c;
            end
            kfe_pkg::CAT_VOL: begin
                w_p = r_var_vol;
                w_x = r_est_vol;
                w_z = r_vol;
            end
            kfe_pkg::CAT_NONE: begin
                w_p = r_var_nav;
                w_x = r_est_nav;
                w_z = r_est_nav;
            end
        endcase
    end

    assign w_den = {1'b0, w_p} + (VW+1)'(r_r);

    kfe_sdiv #(
        .Q_W (FRACTION_BITS),
        .N_W (VW),
        .D_W (VW + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SEL),
        .i_num   (w_p),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_gain)
    );

    kfe_smul #(
        .A_W (VW),
        .B_W (FRACTION_BITS)
    ) u_mul_var (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_done),
        .i_a      (r_p),
        .i_b      (w_gain),
        .o_done   (w_mul_done),
        .o_hi     (w_var_hi),
        .o_sticky (w_var_sticky)
    );

    kfe_smul #(
        .A_W (VW),
        .B_W (FRACTION_BITS)
    ) u_mul_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_done),
        .i_a      (r_diff),
        .i_b      (w_gain),
        .o_done   (),
        .o_hi     (w_step_hi),
        .o_sticky ()
    );

    kfe_exp #(
        .FRAC_W (FRACTION_BITS)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_PEN) && (r_est_vol > r_est_nav)),
        .i_ov    (r_est_vol - r_est_nav),
        .o_done  (w_exp_done),
        .o_exp   (w_exp)
    );

    // p * (1 - K) = p - ceil(p * K)
    assign w_p_new = r_p - w_var_hi - VW'(w_var_sticky);
    assign w_x_new = r_up ? kfe_pkg::sat_val({1'b0, r_x} + {1'b0, w_step_hi})
                          : r_x - w_step_hi;
    assign w_cap   = (r_est_risk >= ONE) ? '0 : ONE - r_est_risk;

    // operand capture
    always_ff @(posedge i_clk) begin
        if (i_obs.valid && i_obs.ready) begin
            r_cat     <= kfe_pkg::t_category'(i_obs.category);
            r_rel     <= i_obs.reliability;
            r_sev     <= i_obs.severity;
            r_has_vol <= i_obs.has_volume_value;
            r_vol     <= i_obs.volume_value;
            r_ts      <= i_obs.timestamp;
        end
        if (r_state == S_NOISE) begin
            r_r <= R_W'(ONE - w_rel_c + EPS);
        end
        if (r_state == S_SEL) begin
            r_p    <= w_p;
            r_x    <= w_x;
            r_up   <= w_z >= w_x;
            r_diff <= (w_z >= w_x) ? w_z - w_x : w_x - w_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_est_nav   <= ONE;
            r_est_vol   <= HALF;
            r_est_risk  <= '0;
            r_pen       <= ONE;
            r_var_nav   <= HALF;
            r_var_vol   <= HALF;
            r_var_risk  <= HALF;
            r_out_valid <= 1'b0;
        end else begin
            if (o_est.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_obs.valid) begin
                        r_state <= S_NOISE;
                    end
                end
                S_NOISE: begin
                    r_var_nav  <= n_var_nav;
                    r_var_vol  <= n_var_vol;
                    r_var_risk <= n_var_risk;
                    r_state    <= w_active ? S_SEL : S_PEN;
                end
                S_SEL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    unique case (r_cat)
                        kfe_pkg::CAT_NAV: begin
                            r_est_nav <= w_x_new;
                            r_var_nav <= w_p_new;
                        end
                        kfe_pkg::CAT_RISK: begin
                            r_est_risk <= w_x_new;
                            r_var_risk <= w_p_new;
                        end
                        kfe_pkg::CAT_VOL: begin
                            r_est_vol <= w_x_new;
                            r_var_vol <= w_p_new;
                        end
                        kfe_pkg::CAT_NONE: ;
                    endcase
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    if (r_cat == kfe_pkg::CAT_RISK && r_est_risk > RISK_LIMIT
                        && r_est_nav > w_cap) begin
                        r_est_nav <= w_cap;
                    end
                    r_state <= S_PEN;
                end
                S_PEN: begin
                    if (r_est_vol > r_est_nav) begin
                        r_state <= S_EXP;
                    end else begin
                        r_pen   <= ONE;
                        r_state <= S_DONE;
                    end
                end
                S_EXP: begin
                    if (w_exp_done) begin
                        r_pen   <= kfe_pkg::sat_val({1'b0, ONE} + {1'b0, w_exp});
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_est.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_nav   <= r_est_nav;
                        r_out_vol   <= r_est_vol;
                        r_out_risk  <= r_est_risk;
                        r_out_pen   <= r_pen;
                        r_out_ts    <= r_ts;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_obs.ready = (r_state == S_IDLE);

    assign o_est.valid            = r_out_valid;
    assign o_est.navigability_out = r_out_nav;
    assign o_est.volume_out       = r_out_vol;
    assign o_est.risk_out         = r_out_risk;
    assign o_est.penalty_out      = r_out_pen;
    assign o_est.stamp_out        = r_out_ts;

endmodule

`default_nettype wire

// File: src/kfe_smul.sv
`default_nettype none

module kfe_smul #(
    parameter int A_W = 24,
    parameter int B_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [A_W-1:0] o_hi,
    output logic           o_sticky
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_b;
    logic             r_sticky;
    logic [A_W:0]     w_sum;

    assign w_sum = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the low product bits out, keep their OR
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_hi     <= '0;
            r_sticky <= 1'b0;
        end else if (r_busy) begin
            r_hi     <= w_sum[A_W:1];
            r_sticky <= r_sticky | w_sum[0];
            r_b      <= r_b >> 1;
        end
    end

    assign o_done   = r_done;
    assign o_hi     = r_hi;
    assign o_sticky = r_sticky;

endmodule

`default_nettype wire

// File: src/kfe_sdiv.sv
`default_nettype none

module kfe_sdiv #(
    parameter int Q_W = 16,
    parameter int N_W = 24,
    parameter int D_W = 25
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [Q_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [Q_W-1:0]   r_q;
    logic [D_W:0]     w_shift;
    logic [D_W:0]     w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle; numerator below divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= D_W'(i_num);
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

// File: src/kfe_exp.sv
`default_nettype none

module kfe_exp #(
    parameter int FRAC_W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kfe_pkg::VAL_W-1:0]   i_ov,
    output logic                        o_done,
    output logic [kfe_pkg::VAL_W-1:0]   o_exp
);

    localparam int VW     = kfe_pkg::VAL_W;
    localparam int SW     = kfe_pkg::EXP_SCALE_W;
    localparam int T_SH   = kfe_pkg::EXP_Q - VW;
    localparam int T_W    = SW - T_SH;
    localparam int N_W    = T_W - FRAC_W;
    localparam int SEG_W  = FRAC_W - kfe_pkg::TBL_IDX_W;
    localparam int PROD_W = kfe_pkg::TBL_STEP_W + SEG_W;
    localparam int TW     = kfe_pkg::TBL_W;
    localparam int XW     = TW + VW + FRAC_W;
    localparam int SH_W   = $clog2(VW + FRAC_W);

    logic                  w_mul_done;
    logic [SW-1:0]         w_mul_hi;
    logic [T_W-1:0]        w_t;
    logic [N_W-1:0]        w_n;
    logic [kfe_pkg::TBL_IDX_W-1:0] w_idx;
    logic [SEG_W-1:0]      w_rem;
    logic [TW-1:0]         w_lo;
    logic [TW-1:0]         w_hi;
    logic [kfe_pkg::TBL_STEP_W-1:0] w_step;
    logic [TW-1:0]         w_m;
    logic [SH_W-1:0]       w_sh;
    logic [XW-1:0]         w_wide;

    logic                  r_v1;
    logic                  r_done;
    logic [TW-1:0]         r_lo;
    logic [PROD_W-1:0]     r_prod;
    logic [4:0]            r_n;
    logic                  r_sat;
    logic [VW-1:0]         r_exp;

    kfe_smul #(
        .A_W (SW),
        .B_W (VW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_a      (kfe_pkg::EXP_SCALE),
        .i_b      (i_ov),
        .o_done   (w_mul_done),
        .o_hi     (w_mul_hi),
        .o_sticky ()
    );

    assign w_t    = w_mul_hi[SW-1:T_SH];
    assign w_n    = w_t[T_W-1:FRAC_W];
    assign w_idx  = w_t[FRAC_W-1 -: kfe_pkg::TBL_IDX_W];
    assign w_rem  = w_t[SEG_W-1:0];
    assign w_lo   = kfe_pkg::POW2_FRAC[{1'b0, w_idx}];
    assign w_hi   = kfe_pkg::POW2_FRAC[{1'b0, w_idx} + 5'd1];
    assign w_step = kfe_pkg::TBL_STEP_W'(w_hi - w_lo);

    assign w_m    = r_lo + TW'(r_prod >> SEG_W);
    assign w_sh   = SH_W'(r_n) + SH_W'(FRAC_W);
    assign w_wide = (XW'(w_m) << w_sh) >> kfe_pkg::TBL_Q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= w_mul_done;
            r_done <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_done) begin
            r_lo   <= w_lo;
            r_prod <= PROD_W'(w_step * w_rem);
            r_n    <= w_n[4:0];
            r_sat  <= w_n >= N_W'(VW);
        end
        if (r_v1) begin
            if (r_sat || w_wide > XW'({VW{1'b1}})) begin
                r_exp <= {VW{1'b1}};
            end else begin
                r_exp <= w_wide[VW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_exp  = r_exp;

endmodule

`default_nettype wire

// File: bench/kfe_estimate_check.sv
module kfe_estimate_check #(
    parameter logic [2:0] NOISE_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kfe_obs_if          i_obs,
    kfe_est_if          i_est,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_risk_caps,
    output int          o_pen_sat,
    output int          o_pen_level
);

    localparam int          FB          = 16;
    localparam logic [63:0] ONE         = 64'd1 << FB;
    localparam logic [63:0] EPS         = (ONE + 64'd50) / 64'd100;
    localparam logic [63:0] RISK_LIMIT  = (ONE * 64'd6 + 64'd5) / 64'd10;
    localparam logic [63:0] TOP24       = 64'hFF_FFFF;
    localparam logic [63:0] LOG2E_Q30   = 64'd1549082005;
    localparam logic [16:0] NOISE_RESET = 17'd655;

    typedef struct packed {
        logic [23:0] nav;
        logic [23:0] vol;
        logic [23:0] risk;
        logic [23:0] pen;
        logic [62:0] ts;
    } t_estimate;

    t_estimate   estimate_q[$];
    logic [16:0] noise;
    logic [23:0] nav_est, vol_est, risk_est, pen_est;
    logic [23:0] nav_var, vol_var, risk_var;
    logic [62:0] last_ts;
    int          fails, checked, risk_caps, pen_sat, pen_level;

    assign o_fail_count = fails;
    assign o_checked    = checked;
    assign o_risk_caps  = risk_caps;
    assign o_pen_sat    = pen_sat;
    assign o_pen_level  = pen_level;

    function automatic logic [23:0] clip24(input logic [63:0] v);
        return (v > TOP24) ? TOP24[23:0] : v[23:0];
    endfunction

    // 2^(k/16) in Q16
    function automatic logic [63:0] pow2_sixteenth(input logic [4:0] k);
        case (k)
            5'd0:    return 64'd65536;
            5'd1:    return 64'd68438;
            5'd2:    return 64'd71468;
            5'd3:    return 64'd74632;
            5'd4:    return 64'd77936;
            5'd5:    return 64'd81386;
            5'd6:    return 64'd84990;
            5'd7:    return 64'd88752;
            5'd8:    return 64'd92682;
            5'd9:    return 64'd96785;
            5'd10:   return 64'd101070;
            5'd11:   return 64'd105545;
            5'd12:   return 64'd110218;
            5'd13:   return 64'd115098;
            5'd14:   return 64'd120193;
            5'd15:   return 64'd125514;
            default: return 64'd131072;
        endcase
    endfunction

    // exp(3 * overflow), saturated
    function automatic logic [63:0] exp_three(input logic [63:0] overflow);
        logic [63:0] t, whole, frac, seg, rem, lo, hi, m;
        t     = ((overflow * 64'd3) * LOG2E_Q30) >> 30;
        whole = t >> FB;
        frac  = t & (ONE - 64'd1);
        if (whole >= 64'd24) return TOP24;
        seg = frac >> (FB - 4);
        rem = frac & ((64'd1 << (FB - 4)) - 64'd1);
        lo  = pow2_sixteenth(seg[4:0]);
        hi  = pow2_sixteenth(seg[4:0] + 5'd1);
        m   = lo + (((hi - lo) * rem) >> (FB - 4));
        m   = m << whole;
        return {40'd0, clip24(m)};
    endfunction

    // returns {estimate, variance} after one gain step toward z
    function automatic logic [47:0] kalman_pull(input logic [23:0] x, p,
                                                input logic [63:0] z, r);
        logic [63:0] xx, pp, gain, nx, np;
        xx   = 64'(x);
        pp   = 64'(p);
        gain = (pp << FB) / (pp + r);
        if (gain > ONE) gain = ONE;
        if (z >= xx) nx = 64'(clip24(xx + ((gain * (z - xx)) >> FB)));
        else nx = xx - ((gain * (xx - z)) >> FB);
        np = (pp * (ONE - gain)) >> FB;
        return {nx[23:0], np[23:0]};
    endfunction

    task automatic check_field(input string field, input logic [62:0] want, got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        logic [63:0] rel, sev, r, cap;
        t_estimate   want, got;
        if (!i_rst_n) begin
            estimate_q.delete();
            noise    = NOISE_RESET;
            nav_est  = ONE[23:0];
            vol_est  = 24'(ONE / 64'd2);
            risk_est = '0;
            pen_est  = ONE[23:0];
            nav_var  = 24'(ONE / 64'd2);
            vol_var  = 24'(ONE / 64'd2);
            risk_var = 24'(ONE / 64'd2);
            last_ts  = '0;
            o_pending <= 0;
        end else begin
            if (i_est.valid && i_est.ready) begin
                got = '{nav: i_est.navigability_out, vol: i_est.volume_out,
                        risk: i_est.risk_out, pen: i_est.penalty_out,
                        ts: i_est.stamp_out};
                if (estimate_q.size() == 0) begin
                    fails++;
                    $display("%0t: estimate with no observation pending, actual %0h",
                             $time, got);
                end else begin
                    want = estimate_q.pop_front();
                    checked++;
                    check_field("navigability", 63'(want.nav), 63'(got.nav));
                    check_field("volume", 63'(want.vol), 63'(got.vol));
                    check_field("risk", 63'(want.risk), 63'(got.risk));
                    check_field("penalty", 63'(want.pen), 63'(got.pen));
                    check_field("stamp", want.ts, got.ts);
                end
            end

            if (psel && penable && pready && paddr == NOISE_ADDR) begin
                if (pwrite) begin
                    noise = pwdata[16:0];
                end else if (prdata !== {15'd0, noise}) begin
                    fails++;
                    $display("%0t: noise register read mismatch, expected %0h, actual %0h",
                             $time, {15'd0, noise}, prdata);
                end
            end

            if (i_obs.valid && i_obs.ready) begin
                rel = (64'(i_obs.reliability) > ONE) ? ONE : 64'(i_obs.reliability);
                sev = (64'(i_obs.severity) > ONE) ? ONE : 64'(i_obs.severity);
                r   = (ONE - rel) + EPS;

                nav_var  = clip24(64'(nav_var) + 64'(noise));
                vol_var  = clip24(64'(vol_var) + 64'(noise));
                risk_var = clip24(64'(risk_var) + 64'(noise));

                case (kfe_pkg::t_category'(i_obs.category))
                    kfe_pkg::CAT_NAV: begin
                        {nav_est, nav_var} = kalman_pull(nav_est, nav_var, ONE - sev, r);
                    end
                    kfe_pkg::CAT_RISK: begin
                        {risk_est, risk_var} = kalman_pull(risk_est, risk_var, sev, r);
                        if (64'(risk_est) > RISK_LIMIT) begin
                            cap = (64'(risk_est) >= ONE) ? 64'd0 : ONE - 64'(risk_est);
                            if (64'(nav_est) > cap) begin
                                nav_est = cap[23:0];
                                risk_caps++;
                            end
                        end
                    end
                    kfe_pkg::CAT_VOL: begin
                        if (i_obs.has_volume_value)
                            {vol_est, vol_var} = kalman_pull(vol_est, vol_var,
                                                             64'(i_obs.volume_value), r);
                    end
                    default: ;
                endcase

                if (vol_est > nav_est)
                    pen_est = clip24(ONE + exp_three(64'(vol_est) - 64'(nav_est)));
                else
                    pen_est = ONE[23:0];
                if (pen_est == TOP24[23:0]) pen_sat++;
                if (vol_est == nav_est) pen_level++;

                last_ts = i_obs.timestamp;
                estimate_q.push_back('{nav: nav_est, vol: vol_est, risk: risk_est,
                                       pen: pen_est, ts: last_ts});
            end
            o_pending <= estimate_q.size();
        end
    end

endmodule

// File: bench/tb_three_channel_scalar_kalman_estimator_unit.sv
module tb_three_channel_scalar_kalman_estimator_unit;

    localparam logic [2:0]  NOISE_ADDR    = 3'd0;
    localparam logic [16:0] NOISE_RESET   = 17'd655;
    localparam logic [16:0] NOISE_MAX     = 17'd65536;
    localparam logic [16:0] UNIT_ONE      = 17'd65536;
    localparam logic [16:0] UNIT_TOP      = 17'h1FFFF;
    localparam logic [23:0] VOL_TOP       = 24'hFF_FFFF;
    localparam logic [62:0] TS_TOP        = {63{1'b1}};
    localparam int          LONG_HOLD     = 300;
    localparam int          DRAIN_CYCLES  = 150;
    localparam int          TIMEOUT_UNITS = 4_000_000;

    typedef enum int {THEME_MIXED, THEME_RISK, THEME_SURGE, THEME_CALM, THEME_QUIET} t_theme;
    typedef enum int {PACE_FULL, PACE_HALF, PACE_SLOW, PACE_MOST} t_pace;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending_count, checked_count, risk_caps, pen_sat, pen_level;
    int obs_sent;
    int holds_wanted;
    int holds_done;

    kfe_obs_if obs_bus ();
    kfe_est_if est_bus ();

    three_channel_scalar_kalman_estimator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_obs   (obs_bus),
        .o_est   (est_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kfe_estimate_check #(
        .NOISE_ADDR (NOISE_ADDR)
    ) estimate_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_obs        (obs_bus),
        .i_est        (est_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_risk_caps  (risk_caps),
        .o_pen_sat    (pen_sat),
        .o_pen_level  (pen_level)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [16:0] pick_unit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return UNIT_ONE;
            2, 3:    return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [23:0] pick_volume();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return VOL_TOP;
            2, 3:    return 24'($urandom);
            default: return 24'($urandom_range(0, 131072));
        endcase
    endfunction

    task automatic offer(input kfe_pkg::t_category cat, input logic [16:0] rel, sev,
                         input logic has_vol, input logic [23:0] vol,
                         input logic [62:0] ts);
        obs_bus.valid            <= 1'b1;
        obs_bus.category         <= cat;
        obs_bus.reliability      <= rel;
        obs_bus.severity         <= sev;
        obs_bus.has_volume_value <= has_vol;
        obs_bus.volume_value     <= vol;
        obs_bus.timestamp        <= ts;
        @(posedge i_clk);
        while (!obs_bus.ready) @(posedge i_clk);
        obs_sent++;
    endtask

    // drop valid, then wait until every expected estimate has been taken
    task automatic settle();
        obs_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic program_noise(input logic [16:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NOISE_ADDR;
        pwdata  <= {15'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_traffic(input int count, input bit quiet_only);
        int                 sent, burst_len, gap;
        t_theme             theme;
        kfe_pkg::t_category cat;
        logic [16:0]        rel, sev;
        logic               has_vol;
        logic [23:0]        vol;
        sent = 0;
        while (sent < count) begin
            burst_len = $urandom_range(1, 12);
            theme = quiet_only ? THEME_QUIET : t_theme'($urandom_range(0, 3));
            repeat (burst_len) begin
                if (sent < count) begin
                    rel     = pick_unit();
                    sev     = pick_unit();
                    has_vol = ($urandom_range(0, 3) != 0);
                    vol     = pick_volume();
                    cat     = kfe_pkg::t_category'($urandom_range(0, 3));
                    case (theme)
                        THEME_RISK: begin
                            cat = ($urandom_range(0, 3) == 0) ? kfe_pkg::CAT_NAV
                                                               : kfe_pkg::CAT_RISK;
                            sev = 17'($urandom_range(45875, 65536));
                            rel = 17'($urandom_range(49152, 65536));
                        end
                        THEME_SURGE: begin
                            cat     = kfe_pkg::CAT_VOL;
                            has_vol = 1'b1;
                            if ($urandom_range(0, 2) != 0)
                                vol = 24'($urandom_range(65536, 262144));
                        end
                        THEME_CALM: begin
                            cat     = $urandom_range(0, 1) ? kfe_pkg::CAT_NAV
                                                           : kfe_pkg::CAT_VOL;
                            sev     = 17'($urandom_range(0, 13107));
                            vol     = 24'($urandom_range(0, 32768));
                            has_vol = 1'b1;
                        end
                        THEME_QUIET: begin
                            cat     = $urandom_range(0, 1) ? kfe_pkg::CAT_NONE
                                                           : kfe_pkg::CAT_VOL;
                            has_vol = 1'b0;
                        end
                        default: ;
                    endcase
                    offer(cat, rel, sev, has_vol, vol, 63'({$urandom, $urandom}));
                    sent++;
                end
            end
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 90);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap != 0) begin
                obs_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : est_sink
        int    seg_len;
        t_pace pace;
        est_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds_done < holds_wanted) begin
                est_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end
            seg_len = $urandom_range(4, 60);
            pace    = t_pace'($urandom_range(0, 3));
            repeat (seg_len) begin
                case (pace)
                    PACE_FULL: est_bus.ready <= 1'b1;
                    PACE_HALF: est_bus.ready <= 1'($urandom_range(0, 1));
                    PACE_SLOW: est_bus.ready <= ($urandom_range(0, 7) == 0);
                    default:   est_bus.ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [16:0] mid_noise;
        holds_wanted = 0;
        holds_done   = 0;
        obs_sent     = 0;
        obs_bus.valid            <= 1'b0;
        obs_bus.category         <= kfe_pkg::CAT_NONE;
        obs_bus.reliability      <= '0;
        obs_bus.severity         <= '0;
        obs_bus.has_volume_value <= 1'b0;
        obs_bus.volume_value     <= '0;
        obs_bus.timestamp        <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= NOISE_ADDR;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset noise: extremes, clamping, each category, volume without value
        offer(kfe_pkg::CAT_NONE, '0, '0, 1'b0, '0, '0);
        offer(kfe_pkg::CAT_NAV, UNIT_ONE, '0, 1'b0, '0, TS_TOP);
        offer(kfe_pkg::CAT_NAV, UNIT_TOP, UNIT_TOP, 1'b1, VOL_TOP,
              63'({$urandom, $urandom}));
        offer(kfe_pkg::CAT_RISK, '0, UNIT_ONE, 1'b0, '0, 63'($urandom));
        offer(kfe_pkg::CAT_RISK, UNIT_ONE, UNIT_TOP, 1'b0, '0, 63'($urandom));
        offer(kfe_pkg::CAT_VOL, UNIT_ONE, '0, 1'b0, VOL_TOP, 63'($urandom));
        offer(kfe_pkg::CAT_VOL, UNIT_ONE, '0, 1'b1, VOL_TOP, TS_TOP);
        offer(kfe_pkg::CAT_VOL, '0, UNIT_ONE, 1'b1, '0, '0);
        offer(kfe_pkg::CAT_NONE, UNIT_TOP, UNIT_TOP, 1'b1, VOL_TOP, 63'($urandom));
        settle();

        program_noise(NOISE_MAX);
        // drive navigability and volume down to the same floor
        repeat (4) offer(kfe_pkg::CAT_NAV, UNIT_ONE, UNIT_ONE, 1'b0, '0, 63'($urandom));
        repeat (4) offer(kfe_pkg::CAT_VOL, UNIT_ONE, '0, 1'b1, '0, 63'($urandom));
        repeat (2) offer(kfe_pkg::CAT_NONE, UNIT_ONE, '0, 1'b0, '0, 63'($urandom));
        // huge volume against low navigability saturates the penalty
        repeat (3) offer(kfe_pkg::CAT_VOL, UNIT_ONE, '0, 1'b1, VOL_TOP, 63'($urandom));

        holds_wanted = 1;
        run_traffic(270, 1'b1);
        run_traffic(300, 1'b0);
        settle();

        program_noise('0);
        run_traffic(330, 1'b0);
        settle();

        mid_noise = 17'($urandom_range(1, 65535));
        program_noise(mid_noise);
        run_traffic(330, 1'b0);
        settle();

        program_noise(NOISE_RESET);
        run_traffic(330, 1'b0);
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d observations sent under noise variance 655, 65536, 0, %0d and 655 again",
                 obs_sent, mid_noise);
        $display("%0d estimates checked: %0d risk caps, %0d saturated penalties, %0d level",
                 checked_count, risk_caps, pen_sat, pen_level);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: three_channel_scalar_kalman_estimator_unit.f
src/kfe_pkg.sv
src/kfe_if.sv
src/kfe_smul.sv
src/kfe_sdiv.sv
src/kfe_exp.sv
src/three_channel_scalar_kalman_estimator_unit.sv
bench/kfe_estimate_check.sv
bench/tb_three_channel_scalar_kalman_estimator_unit.sv
